### rtl/glyph_pixel_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_PIXEL_RASTERIZER_MACROS_SVH
`define GLYPH_PIXEL_RASTERIZER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define GPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define GPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer package
// Shared constants, types and the 5x7 font table of the character generator.
// ----------------------------------------------------------------------------
`default_nettype none

package gpr_pkg;

  localparam int MAX_SCALE   = 2;
  localparam int CELL_W      = 6;
  localparam int CELL_H      = 8;
  localparam int GLYPH_W     = 5;
  localparam int GLYPH_H     = 7;
  localparam int FONT_DEPTH  = 95;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_W   = 2;
  localparam int SCL_W   = $clog2(MAX_SCALE + 1);
  localparam int ROW_W   = $clog2(CELL_H);
  localparam int COL_W   = $clog2(CELL_W + 1);
  localparam int GIDX_W  = $clog2(FONT_DEPTH);
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7E;
  localparam logic [7:0] SUBST_CODE = 8'h3F;

  localparam logic [CFG_W-1:0] SCALE_RESET = CFG_W'(1);

  typedef logic [15:0]         rgb565_t;
  typedef logic [SCL_W-1:0]    scale_t;
  typedef logic [GLYPH_H-1:0]  glyph_col_t;
  typedef glyph_col_t [GLYPH_W-1:0] glyph_t;

  typedef struct packed {
    glyph_t  glyph;
    rgb565_t fore;
    rgb565_t back;
    scale_t  scale;
  } cell_item_t;

  localparam logic [39:0] FONT_ROM [0:FONT_DEPTH-1] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  function automatic glyph_t font_lookup(input logic [GIDX_W-1:0] idx);
    logic [39:0] entry;
    glyph_t      g;
    entry = (idx < GIDX_W'(FONT_DEPTH)) ? FONT_ROM[idx] : '0;
    for (int c = 0; c < GLYPH_W; c++) begin
      g[c] = entry[32 - 8 * c +: GLYPH_H];
    end
    return g;
  endfunction

  function automatic scale_t clamp_scale(input logic [CFG_W-1:0] raw);
    scale_t s;
    if (raw == '0) begin
      s = scale_t'(1);
    end else if (SCL_W'(raw) > scale_t'(MAX_SCALE)) begin
      s = scale_t'(MAX_SCALE);
    end else begin
      s = SCL_W'(raw);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### rtl/glyph_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer
// 5x7 font character generator that emits RGB565 cells as 6-pixel segments.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) takes one character code with its
// foreground and background colors. The result channel (out_valid, out_stall)
// delivers the cell row by row as segments of six pixels, left to right, with
// out_last_segment high on the final segment of each cell.
// cfg_we writes cfg_wdata into the scale register; scale 0 acts as 1 and
// values above the maximum scale act as the maximum.
// A cell is 8 * scale * scale segments, 8 at scale 1 and 32 at scale 2, sent
// one per cycle while out_stall is low. An item goes through the front
// register, queue and cell register; later queued items follow with no gap.
// A two-entry queue between the front and back parts lets new items be taken
// while a cell is still being emitted.
// Reset clears all valid state and sets the scale to 1.
// While out_stall is high the current segment holds and the back end waits;
// once the queue and the front register fill, in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_pixel_rasterizer (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [gpr_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_char_code,
  input  wire gpr_pkg::rgb565_t          in_fore_color,
  input  wire gpr_pkg::rgb565_t          in_back_color,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output gpr_pkg::rgb565_t               out_pixel_a,
  output gpr_pkg::rgb565_t               out_pixel_b,
  output gpr_pkg::rgb565_t               out_pixel_c,
  output gpr_pkg::rgb565_t               out_pixel_d,
  output gpr_pkg::rgb565_t               out_pixel_e,
  output gpr_pkg::rgb565_t               out_pixel_f,
  output logic                           out_last_segment
);
  import gpr_pkg::*;

  logic [CFG_W-1:0] scale_r, scale_nxt;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  cell_item_t       push_item;
  cell_item_t       head_item;

  assign scale_nxt = cfg_we ? cfg_wdata : scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  gpr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_fore_color(in_fore_color),
    .in_back_color(in_back_color),
    .scale_raw    (scale_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  gpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_item (head_item)
  );

  gpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_a     (out_pixel_a),
    .out_pixel_b     (out_pixel_b),
    .out_pixel_c     (out_pixel_c),
    .out_pixel_d     (out_pixel_d),
    .out_pixel_e     (out_pixel_e),
    .out_pixel_f     (out_pixel_f),
    .out_last_segment(out_last_segment)
  );

endmodule

`default_nettype wire

### rtl/gpr_queue.sv
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer item queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire gpr_pkg::cell_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output gpr_pkg::cell_item_t     head_item
);
  import gpr_pkg::*;

  cell_item_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/gpr_front.sv
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer front end
// Accepts character items, substitutes non-printable codes and fetches glyphs.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               in_char_code,
  input  wire gpr_pkg::rgb565_t         in_fore_color,
  input  wire gpr_pkg::rgb565_t         in_back_color,
  input  wire logic [gpr_pkg::CFG_W-1:0] scale_raw,
  input  wire logic                     q_full,
  output logic                          q_push,
  output gpr_pkg::cell_item_t           q_item
);
  import gpr_pkg::*;

  logic              vld_r, vld_nxt;
  cell_item_t        item_r;
  logic              accept;
  logic [7:0]        code_eff;
  logic [GIDX_W-1:0] code_off;

  assign in_stall = vld_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = vld_r && !q_full;
  assign q_item   = item_r;

  always_comb begin
    code_eff = ((in_char_code < FIRST_CODE) || (in_char_code > LAST_CODE)) ?
               SUBST_CODE : in_char_code;
    code_off = GIDX_W'(code_eff - FIRST_CODE);
    vld_nxt  = accept || (vld_r && q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.glyph <= font_lookup(code_off);
      item_r.fore  <= in_fore_color;
      item_r.back  <= in_back_color;
      item_r.scale <= clamp_scale(scale_raw);
    end
  end

endmodule

`default_nettype wire

### rtl/gpr_back.sv
// ----------------------------------------------------------------------------
// Glyph pixel rasterizer back end
// Walks the cell; emits one registered 6-pixel segment a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire gpr_pkg::cell_item_t q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output gpr_pkg::rgb565_t         out_pixel_a,
  output gpr_pkg::rgb565_t         out_pixel_b,
  output gpr_pkg::rgb565_t         out_pixel_c,
  output gpr_pkg::rgb565_t         out_pixel_d,
  output gpr_pkg::rgb565_t         out_pixel_e,
  output gpr_pkg::rgb565_t         out_pixel_f,
  output logic                     out_last_segment
);
  import gpr_pkg::*;

  cell_item_t         cur_r;
  logic               busy_r, busy_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  scale_t             rep_r, rep_nxt;
  scale_t             seg_r, seg_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  scale_t             sub_r, sub_nxt;
  logic               oval_r, oval_nxt;
  rgb565_t            pix_r [CELL_W];
  logic               last_r;

  rgb565_t            pix_nxt [CELL_W];
  logic [COL_W-1:0]   col_end;
  scale_t             sub_end;
  scale_t             smax;
  logic               can_load;
  logic               ld;
  logic               is_last;

  assign out_valid        = oval_r;
  assign out_pixel_a      = pix_r[0];
  assign out_pixel_b      = pix_r[1];
  assign out_pixel_c      = pix_r[2];
  assign out_pixel_d      = pix_r[3];
  assign out_pixel_e      = pix_r[4];
  assign out_pixel_f      = pix_r[5];
  assign out_last_segment = last_r;

  assign smax     = cur_r.scale - scale_t'(1);
  assign can_load = !oval_r || !out_stall;
  assign ld       = busy_r && can_load;
  assign is_last  = (row_r == ROW_W'(CELL_H - 1)) && (rep_r == smax) && (seg_r == smax);
  assign q_pop    = q_valid && (!busy_r || (ld && is_last));

  always_comb begin
    logic [COL_W-1:0] c;
    scale_t           k;
    glyph_col_t       gcol;
    logic             on;
    c = col_r;
    k = sub_r;
    for (int p = 0; p < CELL_W; p++) begin
      gcol = (c < COL_W'(GLYPH_W)) ? cur_r.glyph[c[$clog2(GLYPH_W)-1:0]] : '0;
      on   = (row_r < ROW_W'(GLYPH_H)) && gcol[row_r];
      pix_nxt[p] = on ? cur_r.fore : cur_r.back;
      if (k == smax) begin
        k = '0;
        c = c + COL_W'(1);
      end else begin
        k = k + scale_t'(1);
      end
    end
    col_end = c;
    sub_end = k;
  end

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    rep_nxt  = rep_r;
    seg_nxt  = seg_r;
    col_nxt  = col_r;
    sub_nxt  = sub_r;
    oval_nxt = oval_r;
    if (can_load) begin
      oval_nxt = busy_r;
    end
    if (ld) begin
      if (seg_r == smax) begin
        seg_nxt = '0;
        col_nxt = '0;
        sub_nxt = '0;
        if (rep_r == smax) begin
          rep_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          rep_nxt = rep_r + scale_t'(1);
        end
      end else begin
        seg_nxt = seg_r + scale_t'(1);
        col_nxt = col_end;
        sub_nxt = sub_end;
      end
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      rep_nxt  = '0;
      seg_nxt  = '0;
      col_nxt  = '0;
      sub_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
      row_r  <= '0;
      rep_r  <= '0;
      seg_r  <= '0;
      col_r  <= '0;
      sub_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      oval_r <= oval_nxt;
      row_r  <= row_nxt;
      rep_r  <= rep_nxt;
      seg_r  <= seg_nxt;
      col_r  <= col_nxt;
      sub_r  <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (ld) begin
      for (int p = 0; p < CELL_W; p++) begin
        pix_r[p] <= pix_nxt[p];
      end
      last_r <= is_last;
    end
  end

`include "glyph_pixel_rasterizer_macros.svh"

  `GPR_ASSERT_NEXT(a_mid_cell_busy, ld && !is_last, busy_r && oval_r, "cell ended early")
  `GPR_ASSERT_NEXT(a_cell_done_idle, ld && is_last && !q_valid, !busy_r, "busy after last")
  `GPR_ASSERT_NEXT(a_stall_holds, busy_r && !ld,
                   $stable(row_r) && $stable(rep_r) && $stable(seg_r), "walk moved in stall")
  `GPR_ASSERT_SAME(a_pop_when_free, q_pop, !busy_r || (ld && is_last), "pop while busy")

endmodule

`default_nettype wire
